// ===== hw/rtl/tce_pkg.sv =====
// Package for the toy CPU execute unit: payload structs, opcodes and
// controller/datapath command types. Used by every module in hw/rtl.
`default_nettype none
package tce_pkg;
    localparam int PcBitsDefault  = 16;
    localparam int NumRegsDefault = 10;
    localparam int DataBits       = 32;
    localparam int IdxBits        = 4;
    localparam int OutPcBits      = 16;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MOVE = 4'd4,
        OP_B    = 4'd5,
        OP_CMP  = 4'd6,
        OP_GCD  = 4'd7,
        OP_BEQ  = 4'd8,
        OP_HALT = 4'd9
    } t_opcode;

    typedef struct packed {
        logic [3:0]  mode;
        logic        src_is_imm;
        logic [3:0]  src_index;
        logic [31:0] src_imm;
        logic        tgt_is_imm;
        logic [3:0]  tgt_index;
        logic [31:0] tgt_imm;
    } t_in_word;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [31:0] r0_value;
        logic        halted;
        logic        trapped;
    } t_out_word;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;   // latch the input word
        logic fetch;     // register operands from the register file
        logic execute;   // perform non-iterative work, start iterations
        logic iter;      // one step of divide or gcd
        logic finish;    // write back the iterative result
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic halted;
        logic iterative; // executed operation needs iterations
        logic iter_done;
    } t_dp_sts;
endpackage
`default_nettype wire

// ===== hw/rtl/tce_ctrl.sv =====
// Controller state machine for the toy CPU execute unit.
// Depends on tce_pkg.
`default_nettype none
module tce_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tce_pkg::t_dp_cmd      o_cmd,
    input  wire tce_pkg::t_dp_sts i_sts
);
    import tce_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_ITER, S_FIN} t_state;
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // A new word may enter while the controller is idle and the output stage is free or being drained.
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                if (!i_sts.halted && i_sts.iterative) begin
                    n_state = S_ITER;
                end else begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            S_ITER: begin
                if (i_sts.iter_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.iter = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tce_dpath.sv =====
// Datapath for the toy CPU execute unit: register file, pc, flags,
// multiplier and a shared bit-serial divide/remainder unit. Depends on tce_pkg.
`default_nettype none
module tce_dpath #(
    parameter int PC_BITS  = tce_pkg::PcBitsDefault,
    parameter int NUM_REGS = tce_pkg::NumRegsDefault
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tce_pkg::t_in_word i_word,
    input  wire tce_pkg::t_dp_cmd  i_cmd,
    output tce_pkg::t_dp_sts       o_sts,
    output tce_pkg::t_out_word     o_word
);
    import tce_pkg::*;

    localparam int CntBits = $clog2(DataBits + 1);

    logic [DataBits-1:0] r_regs [NUM_REGS];
    logic [PC_BITS-1:0]  r_pc;
    logic                r_halt, r_trap;
    t_in_word            r_in;
    logic [DataBits-1:0] r_s, r_t;
    logic                r_bad_idx;
    logic                r_is_gcd;
    // Shift-subtract divider: r_quo holds dividend bits then quotient.
    logic [DataBits-1:0] r_quo, r_rem, r_dvs;
    logic [DataBits-1:0] r_ga;
    logic [CntBits-1:0]  r_cnt;
    logic                r_busy, r_done;

    logic [DataBits:0]   w_trial;
    logic [DataBits-1:0] w_rem_sh;
    logic                w_iter_op;
    logic [PC_BITS-1:0]  w_pc_inc;
    t_opcode             w_op;

    assign w_op      = t_opcode'(r_in.mode);
    assign w_iter_op = (w_op == OP_DIV && r_t != '0) ||
                       (w_op == OP_GCD && r_s != '0 && r_t != '0);
    assign w_pc_inc  = r_pc + PC_BITS'(1);
    assign w_rem_sh  = {r_rem[DataBits-2:0], r_quo[DataBits-1]};
    assign w_trial   = {1'b0, w_rem_sh} - {1'b0, r_dvs};

    assign o_sts.halted    = r_halt;
    assign o_sts.iterative = w_iter_op && !r_bad_idx;
    assign o_sts.iter_done = r_done;

    always_comb begin
        o_word          = '0;
        o_word.next_pc  = OutPcBits'(r_pc);
        o_word.r0_value = r_regs[0];
        o_word.halted   = r_halt;
        o_word.trapped  = r_trap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_pc   <= '0;
            r_halt <= 1'b0;
            r_trap <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_in <= i_word;
            end
            if (i_cmd.fetch) begin
                r_bad_idx <= (!r_in.src_is_imm && r_in.src_index >= IdxBits'(NUM_REGS)) ||
                             (!r_in.tgt_is_imm && r_in.tgt_index >= IdxBits'(NUM_REGS));
                r_s <= r_in.src_is_imm ? r_in.src_imm
                                       : r_regs[r_in.src_index < IdxBits'(NUM_REGS)
                                                ? r_in.src_index : '0];
                r_t <= r_in.tgt_is_imm ? r_in.tgt_imm
                                       : r_regs[r_in.tgt_index < IdxBits'(NUM_REGS)
                                                ? r_in.tgt_index : '0];
            end
            if (i_cmd.execute && !r_halt) begin
                r_pc <= w_pc_inc;
                if (r_bad_idx) begin
                    r_halt <= 1'b1;
                    r_trap <= 1'b1;
                end else begin
                    unique case (w_op)
                        OP_ADD: r_regs[0] <= r_s + r_t;
                        OP_SUB: r_regs[0] <= r_s - r_t;
                        OP_MUL: r_regs[0] <= r_s * r_t;
                        OP_CMP: r_regs[0] <= DataBits'(r_s == r_t);
                        OP_DIV, OP_GCD: begin
                            if (!w_iter_op) begin
                                r_trap <= 1'b1;
                            end else begin
                                r_is_gcd <= (w_op == OP_GCD);
                                r_quo    <= r_s;
                                r_dvs    <= r_t;
                                r_ga     <= r_s;
                                r_rem    <= '0;
                                r_cnt    <= '0;
                                r_busy   <= 1'b1;
                                r_done   <= 1'b0;
                            end
                        end
                        OP_MOVE: begin
                            if (!r_in.src_is_imm) begin
                                r_regs[r_in.src_index] <= r_t;
                            end
                        end
                        OP_B: r_pc <= PC_BITS'(r_s);
                        OP_BEQ: begin
                            if (r_regs[0] == r_s) begin
                                r_pc <= PC_BITS'(r_t);
                            end
                        end
                        OP_HALT: r_halt <= 1'b1;
                        default: begin
                            r_halt <= 1'b1;
                            r_trap <= 1'b1;
                        end
                    endcase
                end
            end
            // One quotient bit per step; gcd chains remainders a % b.
            if (i_cmd.iter && r_busy) begin
                if (!w_trial[DataBits]) begin
                    r_rem <= w_trial[DataBits-1:0];
                end else begin
                    r_rem <= w_rem_sh;
                end
                r_quo <= {r_quo[DataBits-2:0], !w_trial[DataBits]};
                if (r_cnt == CntBits'(DataBits - 1)) begin
                    r_cnt <= '0;
                    if (!r_is_gcd) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else if (w_trial[DataBits] ? (w_rem_sh == '0)
                                                   : (w_trial[DataBits-1:0] == '0)) begin
                        r_ga   <= r_dvs;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        // Next pair: (b, a mod b).
                        r_ga  <= r_dvs;
                        r_quo <= r_dvs;
                        r_dvs <= w_trial[DataBits] ? w_rem_sh : w_trial[DataBits-1:0];
                        r_rem <= '0;
                    end
                end else begin
                    r_cnt <= r_cnt + CntBits'(1);
                end
            end
            if (i_cmd.finish) begin
                r_done    <= 1'b0;
                r_regs[0] <= r_is_gcd ? r_ga : r_quo;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/toy_cpu_execute_unit.sv =====
// Top level of the toy CPU execute unit.
// Depends on tce_pkg, tce_ctrl and tce_dpath.
//
// Usage: one instruction word enters on the input channel (i_in_valid /
// o_in_ready, payload i_in_word) and exactly one status word leaves on the
// output channel (o_out_valid / i_out_ready, payload o_out_word) with the
// next pc, r0 and the sticky halt and trap flags.
//
// Sequence: a simple operation passes through the fetch and the execute state
// before its result word is valid. Divide and gcd run on one shared
// bit-serial unit that produces one quotient bit per cycle: divide runs 32
// steps, then the controller sees completion and writes back the result in
// the finish state; gcd runs 32 steps per Euclid remainder step, then ends
// the same way. The controller works on one word at a time; a new word is
// taken in the cycle the previous result is taken or the output register
// is empty.
//
// Reset clears the register file, pc and both flags. While halted, words
// are still accepted and answered with the current state unchanged.
// If the receiver stalls, the result word holds and no new word enters.
`default_nettype none
module toy_cpu_execute_unit #(
    parameter int PC_BITS  = tce_pkg::PcBitsDefault,
    parameter int NUM_REGS = tce_pkg::NumRegsDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tce_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output tce_pkg::t_out_word      o_out_word
);
    import tce_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    tce_dpath #(
        .PC_BITS  (PC_BITS),
        .NUM_REGS (NUM_REGS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_in_word),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_word  (o_out_word)
    );
endmodule
`default_nettype wire
